### rtl/core/cbr_pkg.sv
// cbr_pkg: widths, outcome codes, stage context type and saturation helper
// for the collision bounce response pipeline. no dependencies.
package cbr_pkg;

	localparam int VW   = 25;  // velocity, signed q16.8
	localparam int DIRW = 16;  // direction, signed q1.14
	localparam int MW   = 24;  // mass and min speed, unsigned q16.8
	localparam int EW   = 10;  // elasticity, unsigned q2.8
	localparam int OCW  = 2;

	localparam int PW   = 28;      // projected speed
	localparam int DENW = MW + 1;  // mass sum
	localparam int NW   = 55;      // solve numerator, signed
	localparam int RW   = 56;      // numerator magnitude plus half divisor
	localparam int QW   = 29;      // quotient bits, one per divider stage

	localparam logic [OCW-1:0] OC_MOBILE  = 2'd0;
	localparam logic [OCW-1:0] OC_FIXTURE = 2'd1;
	localparam logic [OCW-1:0] OC_VETO    = 2'd2;
	localparam logic [OCW-1:0] OC_ZERO_A  = 2'd3;

	localparam logic signed [37:0] VMAX = 38'sd16777215;
	localparam logic signed [37:0] VMIN = -38'sd16777216;

	typedef struct packed {
		logic signed [VW-1:0]   ax;
		logic signed [VW-1:0]   ay;
		logic signed [VW-1:0]   bx;
		logic signed [VW-1:0]   by;
		logic signed [DIRW-1:0] dx;
		logic signed [DIRW-1:0] dy;
		logic [MW-1:0]          ma;
		logic [MW-1:0]          mb;
		logic [EW-1:0]          ea;
		logic [EW-1:0]          eb;
		logic [OCW-1:0]         oc;
		logic                   neg;
		logic signed [PW-1:0]   pa;
		logic signed [PW-1:0]   pb;
	} ctx_t;

	function automatic logic signed [VW-1:0] sat_vel(input logic signed [37:0] v);
		logic signed [VW-1:0] r;
		if (v > VMAX) begin
			r = VMAX[VW-1:0];
		end else if (v < VMIN) begin
			r = VMIN[VW-1:0];
		end else begin
			r = v[VW-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/cbr_if.sv
// cbr_if: valid/ready channels for collision requests and bounce responses.
// depends on cbr_pkg for field widths.
interface cbr_coll_if;
	import cbr_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [VW-1:0]   vel_a_x;
	logic signed [VW-1:0]   vel_a_y;
	logic signed [VW-1:0]   vel_b_x;
	logic signed [VW-1:0]   vel_b_y;
	logic signed [DIRW-1:0] dir_x;
	logic signed [DIRW-1:0] dir_y;
	logic [MW-1:0]          mass_a;
	logic [MW-1:0]          mass_b;
	logic [EW-1:0]          elast_a;
	logic [EW-1:0]          elast_b;
	logic                   vetoed;

	modport source (output valid, vel_a_x, vel_a_y, vel_b_x, vel_b_y, dir_x, dir_y,
		mass_a, mass_b, elast_a, elast_b, vetoed, input ready);
	modport sink (input valid, vel_a_x, vel_a_y, vel_b_x, vel_b_y, dir_x, dir_y,
		mass_a, mass_b, elast_a, elast_b, vetoed, output ready);
endinterface

interface cbr_resp_if;
	import cbr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [VW-1:0] new_a_x;
	logic signed [VW-1:0] new_a_y;
	logic signed [VW-1:0] new_b_x;
	logic signed [VW-1:0] new_b_y;
	logic [OCW-1:0]       outcome;

	modport source (output valid, new_a_x, new_a_y, new_b_x, new_b_y, outcome, input ready);
	modport sink (input valid, new_a_x, new_a_y, new_b_x, new_b_y, outcome, output ready);
endinterface

### rtl/core/cbr_div.sv
// cbr_div: pipelined restoring divider, one quotient bit per stage.
// depends on cbr_pkg; expects num < den * 2**QB.
module cbr_div #(
	parameter int QB  = cbr_pkg::QW,
	parameter int RB  = cbr_pkg::RW,
	parameter int DB  = cbr_pkg::DENW
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RB-1:0] num,
	input  logic [DB-1:0] den,
	output logic [QB-1:0] quo
);
	logic [RB-1:0] rem_s [QB];
	logic [DB-1:0] den_s [QB];
	logic [QB-1:0] quo_s [QB];

	for (genvar i = 0; i < QB; i++) begin : g_stage
		localparam int SH = QB - 1 - i;
		logic [RB-1:0] rem_in;
		logic [DB-1:0] den_in;
		logic [QB-1:0] quo_in;
		logic [RB-1:0] trial;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = RB'(den_in) << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i] <= den_in;
				if (rem_in >= trial) begin
					rem_s[i] <= rem_in - trial;
					quo_s[i] <= {quo_in[QB-2:0], 1'b1};
				end else begin
					rem_s[i] <= rem_in;
					quo_s[i] <= {quo_in[QB-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[QB-1];
endmodule

### rtl/core/collision_bounce_response.sv
// collision_bounce_response: two-body bounce along a contact direction.
// an accepted transaction passes 4 setup stages, 29 divider stages and
// 6 response stages; throughput one transaction per cycle unless stalled.
// the whole pipeline advances together; it holds when the result is not taken.
// arst_n clears all valid bits and sets min_speed_q to 10240.
// depends on cbr_pkg, cbr_if, cbr_div.
module collision_bounce_response (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [cbr_pkg::MW-1:0] cfg_wdata,
	cbr_coll_if.sink             coll,
	cbr_resp_if.source           resp
);
	import cbr_pkg::*;

	localparam int SD   = 4 + QW;  // first response stage index
	localparam int NSTG = SD + 6;

	logic [MW-1:0]    min_speed_q;
	logic             adv;
	logic [NSTG-1:0]  vld_s;
	ctx_t             ctx_s [NSTG];
	ctx_t             ctx_nx [NSTG];
	ctx_t             ctx_in;

	assign adv = !vld_s[NSTG-1] || resp.ready;
	assign coll.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q <= MW'(10240);
		end else if (cfg_we) begin
			min_speed_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-2:0], coll.valid};
		end
	end

	// stage 1: capture and classify, four projection products
	always_comb begin
		ctx_in = '0;
		ctx_in.ax = coll.vel_a_x;
		ctx_in.ay = coll.vel_a_y;
		ctx_in.bx = coll.vel_b_x;
		ctx_in.by = coll.vel_b_y;
		ctx_in.dx = coll.dir_x;
		ctx_in.dy = coll.dir_y;
		ctx_in.ma = coll.mass_a;
		ctx_in.mb = coll.mass_b;
		ctx_in.ea = coll.elast_a;
		ctx_in.eb = coll.elast_b;
		if (coll.mass_a == '0) begin
			ctx_in.oc = OC_ZERO_A;
		end else if (coll.vetoed) begin
			ctx_in.oc = OC_VETO;
		end else if (coll.mass_b == '0) begin
			ctx_in.oc = OC_FIXTURE;
		end else begin
			ctx_in.oc = OC_MOBILE;
		end
	end

	logic signed [40:0] pax_s1, pay_s1, pbx_s1, pby_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			pax_s1 <= coll.vel_a_x * coll.dir_x;
			pay_s1 <= coll.vel_a_y * coll.dir_y;
			pbx_s1 <= coll.vel_b_x * coll.dir_x;
			pby_s1 <= coll.vel_b_y * coll.dir_y;
		end
	end

	// stage 2: rounded projections
	logic signed [41:0] suma, sumb;
	assign suma = 42'(pax_s1) + 42'(pay_s1) + 42'sd8192;
	assign sumb = 42'(pbx_s1) + 42'(pby_s1) + 42'sd8192;

	// stage 3: solve numerator terms
	logic signed [VW-1:0]   mdiff;
	logic signed [52:0]     nta_s3;
	logic signed [53:0]     ntb_s3;
	logic [DENW-1:0]        den_s3;
	assign mdiff = $signed({1'b0, ctx_s[1].ma}) - $signed({1'b0, ctx_s[1].mb});

	always_ff @(posedge clk) begin
		if (adv) begin
			nta_s3 <= ctx_s[1].pa * mdiff;
			ntb_s3 <= $signed({1'b0, ctx_s[1].mb, 1'b0}) * ctx_s[1].pb;
			den_s3 <= DENW'(ctx_s[1].ma) + DENW'(ctx_s[1].mb);
		end
	end

	// stage 4: sign and magnitude, half divisor added for round to nearest
	logic signed [RW-1:0] num_sx;
	logic signed [RW-1:0] num_abs;
	logic [RW-1:0]        mag_s4;
	logic [DENW-1:0]      den_s4;
	assign num_sx  = RW'(NW'(nta_s3) + NW'(ntb_s3));
	assign num_abs = num_sx[RW-1] ? -num_sx : num_sx;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s4 <= $unsigned(num_abs) + RW'(den_s3 >> 1);
			den_s4 <= den_s3;
		end
	end

	always_comb begin
		ctx_nx[0] = ctx_in;
		for (int i = 1; i < NSTG; i++) begin
			ctx_nx[i] = ctx_s[i-1];
		end
		ctx_nx[1].pa = PW'(suma >>> 14);
		ctx_nx[1].pb = PW'(sumb >>> 14);
		ctx_nx[3].neg = num_sx[RW-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NSTG; i++) begin
				ctx_s[i] <= ctx_nx[i];
			end
		end
	end

	logic [QW-1:0] quo;

	cbr_div #(
		.QB(QW),
		.RB(RW),
		.DB(DENW)
	) u_div (
		.clk (clk),
		.en  (adv),
		.num (mag_s4),
		.den (den_s4),
		.quo (quo)
	);

	// response 1: signed result, fixture reflects a
	ctx_t                 cq;
	logic signed [QW:0]   qs;
	logic signed [QW:0]   an;
	logic signed [30:0]   sa_r1, sb_r1;
	assign cq = ctx_s[SD-1];
	assign qs = $signed({1'b0, quo});
	assign an = cq.neg ? -qs : qs;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cq.oc == OC_FIXTURE) begin
				sa_r1 <= -31'(cq.pa);
			end else begin
				sa_r1 <= 31'(an);
			end
			sb_r1 <= 31'(an) + 31'(cq.pa) - 31'(cq.pb);
		end
	end

	// response 2: elasticity products
	logic signed [41:0] pra_r2, prb_r2;
	always_ff @(posedge clk) begin
		if (adv) begin
			pra_r2 <= sa_r1 * $signed({1'b0, ctx_s[SD].ea});
			prb_r2 <= sb_r1 * $signed({1'b0, ctx_s[SD].eb});
		end
	end

	// response 3: rounded scale and min speed clip
	logic signed [33:0] ra, rb, minp;
	logic signed [33:0] ra_r3, rb_r3;
	assign ra   = 34'((pra_r2 + 42'sd128) >>> 8);
	assign rb   = 34'((prb_r2 + 42'sd128) >>> 8);
	assign minp = $signed({10'd0, min_speed_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			ra_r3 <= (ra < minp && ra > -minp) ? '0 : ra;
			rb_r3 <= (rb < minp && rb > -minp) ? '0 : rb;
		end
	end

	// response 4: change along the direction
	logic signed [34:0] da_r4, db_r4;
	always_ff @(posedge clk) begin
		if (adv) begin
			da_r4 <= 35'(ra_r3) - 35'(ctx_s[SD+2].pa);
			db_r4 <= 35'(rb_r3) - 35'(ctx_s[SD+2].pb);
		end
	end

	// response 5: spread the change over x and y
	logic signed [50:0] dax_r5, day_r5, dbx_r5, dby_r5;
	always_ff @(posedge clk) begin
		if (adv) begin
			dax_r5 <= da_r4 * ctx_s[SD+3].dx;
			day_r5 <= da_r4 * ctx_s[SD+3].dy;
			dbx_r5 <= db_r4 * ctx_s[SD+3].dx;
			dby_r5 <= db_r4 * ctx_s[SD+3].dy;
		end
	end

	// response 6: round, add, saturate, pick pass-through
	ctx_t                 c5;
	logic signed [37:0]   sax, say, sbx, sby;
	logic signed [VW-1:0] nax_r6, nay_r6, nbx_r6, nby_r6;
	assign c5  = ctx_s[SD+4];
	assign sax = 38'(c5.ax) + 38'(37'((dax_r5 + 51'sd8192) >>> 14));
	assign say = 38'(c5.ay) + 38'(37'((day_r5 + 51'sd8192) >>> 14));
	assign sbx = 38'(c5.bx) + 38'(37'((dbx_r5 + 51'sd8192) >>> 14));
	assign sby = 38'(c5.by) + 38'(37'((dby_r5 + 51'sd8192) >>> 14));

	always_ff @(posedge clk) begin
		if (adv) begin
			case (c5.oc)
				OC_MOBILE: begin
					nax_r6 <= sat_vel(sax);
					nay_r6 <= sat_vel(say);
					nbx_r6 <= sat_vel(sbx);
					nby_r6 <= sat_vel(sby);
				end
				OC_FIXTURE: begin
					nax_r6 <= sat_vel(sax);
					nay_r6 <= sat_vel(say);
					nbx_r6 <= c5.bx;
					nby_r6 <= c5.by;
				end
				default: begin
					nax_r6 <= c5.ax;
					nay_r6 <= c5.ay;
					nbx_r6 <= c5.bx;
					nby_r6 <= c5.by;
				end
			endcase
		end
	end

	assign resp.valid   = vld_s[NSTG-1];
	assign resp.new_a_x = nax_r6;
	assign resp.new_a_y = nay_r6;
	assign resp.new_b_x = nbx_r6;
	assign resp.new_b_y = nby_r6;
	assign resp.outcome = ctx_s[NSTG-1].oc;

	// a held result keeps every stage in place
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved while output stalled");

	a_pass_a: assert property (@(posedge clk) disable iff (!arst_n)
		resp.valid && (resp.outcome == OC_VETO || resp.outcome == OC_ZERO_A)
		|-> resp.new_a_x == ctx_s[NSTG-1].ax && resp.new_a_y == ctx_s[NSTG-1].ay)
		else $error("pass-through outcome changed body a");

	a_fixture_b: assert property (@(posedge clk) disable iff (!arst_n)
		resp.valid && resp.outcome == OC_FIXTURE
		|-> resp.new_b_x == ctx_s[NSTG-1].bx && resp.new_b_y == ctx_s[NSTG-1].by)
		else $error("fixture outcome changed body b");

	a_zero_mass: assert property (@(posedge clk) disable iff (!arst_n)
		resp.valid && ctx_s[NSTG-1].ma == '0 |-> resp.outcome == OC_ZERO_A)
		else $error("zero mass a not flagged");
endmodule
